@@ hdl/cmaf_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex moving average filter package
// Shared widths, register and mode codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package cmaf_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STAGE_W    = 24;
    localparam int SUM_W      = 24;
    localparam int GAIN_W     = 17;
    localparam int QUOT_W     = 25;
    localparam int DIV_STEP_W = 5;
    localparam int RING_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic [2:0] MODE_SMA  = 3'd0;
    localparam logic [2:0] MODE_EMA  = 3'd1;
    localparam logic [2:0] MODE_MMA  = 3'd2;
    localparam logic [2:0] MODE_DEMA = 3'd3;
    localparam logic [2:0] MODE_TEMA = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXP_MUL,
        ST_EXP_ADD,
        ST_EXP_OUT,
        ST_SMA_UPD,
        ST_SMA_READ,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

endpackage

@@ hdl/cmaf_ring.sv @@
// ----------------------------------------------------------------------------
// Sample window ring
// One write port and one registered read port holding packed complex samples.
// ----------------------------------------------------------------------------
module cmaf_ring #(
    parameter int DEPTH = 128
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(DEPTH)-1:0]           i_waddr,
    input  logic [cmaf_pkg::RING_W-1:0]        i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(DEPTH)-1:0]           i_raddr,
    output logic [cmaf_pkg::RING_W-1:0]        o_rdata
);

    logic [cmaf_pkg::RING_W-1:0] r_mem [DEPTH];
    logic [cmaf_pkg::RING_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/cmaf_smooth.sv @@
// ----------------------------------------------------------------------------
// Shared smoother step
// Computes e + round((x - e) * alpha / 2^16) with one registered multiply.
// ----------------------------------------------------------------------------
module cmaf_smooth (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic signed [cmaf_pkg::STAGE_W-1:0]  i_e,
    input  logic signed [cmaf_pkg::STAGE_W-1:0]  i_x,
    input  logic [cmaf_pkg::GAIN_W-1:0]          i_gain,
    output logic signed [cmaf_pkg::STAGE_W-1:0]  o_e_next
);

    localparam int SW = cmaf_pkg::STAGE_W;
    localparam int GW = cmaf_pkg::GAIN_W;
    localparam int PW = SW + 1 + GW + 1;

    logic signed [SW:0]   w_diff;
    logic signed [GW:0]   w_gain;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] w_round;

    assign w_diff = {i_x[SW-1], i_x} - {i_e[SW-1], i_e};
    assign w_gain = {1'b0, i_gain};

    // The product register splits the multiply from the rounding add.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_diff * w_gain;
        end
    end

    // The true result lies between e and x, so a modular add is exact.
    assign w_round  = r_prod + PW'(32768);
    assign o_e_next = i_e + w_round[SW+15:16];

endmodule

@@ hdl/cmaf_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cmaf_div #(
    parameter int DIVISOR_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cmaf_pkg::QUOT_W-1:0]   i_dividend,
    input  logic [DIVISOR_W-1:0]          i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [cmaf_pkg::QUOT_W-1:0]   o_quot
);

    localparam int QW = cmaf_pkg::QUOT_W;
    localparam int CW = cmaf_pkg::DIV_STEP_W;

    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [QW-1:0]        r_quo;
    logic [CW-1:0]        r_steps;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVISOR_W:0]   w_shift;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[QW-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= CW'(QW);
            end else if (r_busy) begin
                r_steps <= r_steps - CW'(1);
                if (r_steps == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ hdl/complex_moving_average_filter.sv @@
// ----------------------------------------------------------------------------
// Complex moving average filter
// SMA, EMA, MMA, DEMA and TEMA over complex Q1.15 samples, run by a small
// sequencer around one shared multiplier and one shared divider.
//
// Channel  Dir  Handshake                  Payload
// sample   in   i_in_valid / o_in_stall    i_sample_re, i_sample_im,
//                                          i_first_of_channel
// result   out  o_out_valid / i_out_stall  o_avg_re, o_avg_im, o_saturated
// config   in   psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// Smoother modes run S = 1, 2 or 3 cascaded stages per word, each stage a
// multiply step and an add step for each part; a first word of a channel
// only seeds the stages. SMA runs the 25-step divider once for each part.
// Reset is synchronous and active low and needs no clearing pass. A finished
// word waits in the output register while the next sample word is taken; the
// sequencer holds at its end only when the output register is still full.
// ----------------------------------------------------------------------------
module complex_moving_average_filter #(
    parameter int WINDOW_MAX = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [cmaf_pkg::SAMPLE_W-1:0]    i_sample_re,
    input  logic signed [cmaf_pkg::SAMPLE_W-1:0]    i_sample_im,
    input  logic                                    i_first_of_channel,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [cmaf_pkg::SAMPLE_W-1:0]    o_avg_re,
    output logic signed [cmaf_pkg::SAMPLE_W-1:0]    o_avg_im,
    output logic                                    o_saturated,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [cmaf_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [cmaf_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [cmaf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int NW = (CW > 8) ? CW : 8;
    localparam int SW = cmaf_pkg::STAGE_W;
    localparam int XW = cmaf_pkg::SAMPLE_W;
    localparam int UW = cmaf_pkg::SUM_W;
    localparam int QW = cmaf_pkg::QUOT_W;
    localparam int DW = cmaf_pkg::APB_DATA_W;

    // Registers
    cmaf_pkg::t_state r_state;
    cmaf_pkg::t_state n_state;
    logic [2:0]                  r_mode;
    logic [7:0]                  r_window;
    logic [cmaf_pkg::GAIN_W-1:0] r_gain;
    logic [UW-1:0]               r_sum_re;
    logic [UW-1:0]               r_sum_im;
    logic [AW-1:0]               r_head;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               r_cnt;
    logic signed [SW-1:0]        r_e1_re;
    logic signed [SW-1:0]        r_e1_im;
    logic signed [SW-1:0]        r_e2_re;
    logic signed [SW-1:0]        r_e2_im;
    logic signed [SW-1:0]        r_e3_re;
    logic signed [SW-1:0]        r_e3_im;
    logic [1:0]                  r_stg;
    logic                        r_comp;
    logic [XW-1:0]               r_x_re;
    logic [XW-1:0]               r_x_im;
    logic [XW-1:0]               r_res_re;
    logic [XW-1:0]               r_res_im;
    logic                        r_res_sat;
    logic                        r_out_valid;
    logic [XW-1:0]               r_out_re;
    logic [XW-1:0]               r_out_im;
    logic                        r_out_sat;

    // Sequencer controls
    logic w_in_stall;
    logic w_in_accept;
    logic w_mul_load;
    logic w_stage_wr;
    logic w_exp_take;
    logic w_sma_fill;
    logic w_ring_rd;
    logic w_sma_repl;
    logic w_div_start;
    logic w_div_take;
    logic w_out_load;

    // Datapath
    logic                        w_cfg_wr;
    logic                        w_exp_mode;
    logic [1:0]                  w_last_stg;
    logic [cmaf_pkg::GAIN_W-1:0] w_gain;
    logic [NW-1:0]               w_win_ext;
    logic [NW-1:0]               w_win_clamp;
    logic [CW-1:0]               w_n;
    logic                        w_fill_open;
    logic [CW-1:0]               w_head_inc;
    logic signed [SW-1:0]        w_sm_e;
    logic signed [SW-1:0]        w_sm_x;
    logic signed [SW-1:0]        w_sm_next;
    logic [cmaf_pkg::RING_W-1:0] w_entry;
    logic [cmaf_pkg::RING_W-1:0] w_old;
    logic                        w_ring_we;
    logic [AW-1:0]               w_ring_waddr;
    logic [UW-1:0]               w_sum_sel;
    logic [UW-1:0]               w_mag;
    logic [QW-1:0]               w_dividend;
    logic                        w_div_busy;
    logic                        w_div_done;
    logic [QW-1:0]               w_quot;
    logic [16:0]                 w_exp_re;
    logic [16:0]                 w_exp_im;

    // Cascade output: e1, 2e1-e2 or 3e1-3e2+e3, rounded to Q1.15 and clipped.
    function automatic logic [16:0] exp_result(
        input logic [2:0]           mode,
        input logic signed [SW-1:0] e1,
        input logic signed [SW-1:0] e2,
        input logic signed [SW-1:0] e3
    );
        logic signed [27:0] a1;
        logic signed [27:0] a2;
        logic signed [27:0] a3;
        logic signed [27:0] acc;
        logic signed [27:0] rnd;
        logic signed [19:0] sh;
        logic [15:0]        val;
        logic               clip;
        a1 = 28'(e1);
        a2 = 28'(e2);
        a3 = 28'(e3);
        case (mode)
            cmaf_pkg::MODE_DEMA: acc = (a1 <<< 1) - a2;
            cmaf_pkg::MODE_TEMA: acc = (a1 <<< 1) + a1 - (a2 <<< 1) - a2 + a3;
            default:             acc = a1;
        endcase
        rnd  = acc + 28'sd128;
        sh   = rnd[27:8];
        clip = 1'b1;
        if (sh > 20'sd32767) begin
            val = 16'h7FFF;
        end else if (sh < -20'sd32768) begin
            val = 16'h8000;
        end else begin
            val  = sh[15:0];
            clip = 1'b0;
        end
        return {clip && (mode == cmaf_pkg::MODE_DEMA || mode == cmaf_pkg::MODE_TEMA), val};
    endfunction

    // Applies the sign of the sum to the magnitude quotient and clips.
    function automatic logic [15:0] sma_result(input logic neg, input logic [QW-1:0] q);
        logic [15:0] val;
        if (neg) begin
            val = (q > QW'(32768)) ? 16'h8000 : 16'h0000 - q[15:0];
        end else begin
            val = (q > QW'(32767)) ? 16'h7FFF : q[15:0];
        end
        return val;
    endfunction

    assign w_cfg_wr   = psel && penable && pwrite;
    assign w_exp_mode = (r_mode >= cmaf_pkg::MODE_EMA) && (r_mode <= cmaf_pkg::MODE_TEMA);
    assign w_last_stg = (r_mode == cmaf_pkg::MODE_TEMA) ? 2'd2 :
                        (r_mode == cmaf_pkg::MODE_DEMA) ? 2'd1 : 2'd0;
    assign w_gain     = (r_gain > cmaf_pkg::GAIN_ONE) ? cmaf_pkg::GAIN_ONE : r_gain;

    // A window of zero acts as one; a window past the ring depth is capped.
    assign w_win_ext   = NW'(r_window);
    assign w_win_clamp = (w_win_ext == '0) ? NW'(1) :
                         (w_win_ext > NW'(WINDOW_MAX)) ? NW'(WINDOW_MAX) : w_win_ext;
    assign w_n         = w_win_clamp[CW-1:0];
    assign w_fill_open = r_fill < w_n;
    assign w_head_inc  = CW'(r_head) + CW'(1);

    assign w_entry     = {r_x_im, r_x_re};
    assign w_in_accept = i_in_valid && !w_in_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmaf_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    if (w_exp_mode) begin
                        n_state = i_first_of_channel ? cmaf_pkg::ST_EXP_OUT
                                                     : cmaf_pkg::ST_EXP_MUL;
                    end else begin
                        n_state = cmaf_pkg::ST_SMA_UPD;
                    end
                end
            end
            cmaf_pkg::ST_EXP_MUL: n_state = cmaf_pkg::ST_EXP_ADD;
            cmaf_pkg::ST_EXP_ADD: begin
                if (r_comp && r_stg == w_last_stg) begin
                    n_state = cmaf_pkg::ST_EXP_OUT;
                end else begin
                    n_state = cmaf_pkg::ST_EXP_MUL;
                end
            end
            cmaf_pkg::ST_EXP_OUT: n_state = cmaf_pkg::ST_DONE;
            cmaf_pkg::ST_SMA_UPD: begin
                n_state = w_fill_open ? cmaf_pkg::ST_DIV_GO : cmaf_pkg::ST_SMA_READ;
            end
            cmaf_pkg::ST_SMA_READ: n_state = cmaf_pkg::ST_DIV_GO;
            cmaf_pkg::ST_DIV_GO:   n_state = cmaf_pkg::ST_DIV_WAIT;
            cmaf_pkg::ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = r_comp ? cmaf_pkg::ST_DONE : cmaf_pkg::ST_DIV_GO;
                end
            end
            cmaf_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = cmaf_pkg::ST_IDLE;
                end
            end
            default: n_state = cmaf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_stall  = 1'b1;
        w_mul_load  = 1'b0;
        w_stage_wr  = 1'b0;
        w_exp_take  = 1'b0;
        w_sma_fill  = 1'b0;
        w_ring_rd   = 1'b0;
        w_sma_repl  = 1'b0;
        w_div_start = 1'b0;
        w_div_take  = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            cmaf_pkg::ST_IDLE:     w_in_stall  = 1'b0;
            cmaf_pkg::ST_EXP_MUL:  w_mul_load  = 1'b1;
            cmaf_pkg::ST_EXP_ADD:  w_stage_wr  = 1'b1;
            cmaf_pkg::ST_EXP_OUT:  w_exp_take  = 1'b1;
            cmaf_pkg::ST_SMA_UPD: begin
                w_sma_fill = w_fill_open;
                w_ring_rd  = !w_fill_open;
            end
            cmaf_pkg::ST_SMA_READ: w_sma_repl  = 1'b1;
            cmaf_pkg::ST_DIV_GO:   w_div_start = 1'b1;
            cmaf_pkg::ST_DIV_WAIT: w_div_take  = w_div_done;
            cmaf_pkg::ST_DONE:     w_out_load  = !r_out_valid || !i_out_stall;
            default: begin
            end
        endcase
    end

    // Operand selection for the shared smoother step.
    always_comb begin
        case (r_stg)
            2'd0: begin
                w_sm_e = r_comp ? r_e1_im : r_e1_re;
                w_sm_x = r_comp ? {r_x_im, 8'h00} : {r_x_re, 8'h00};
            end
            2'd1: begin
                w_sm_e = r_comp ? r_e2_im : r_e2_re;
                w_sm_x = r_comp ? r_e1_im : r_e1_re;
            end
            default: begin
                w_sm_e = r_comp ? r_e3_im : r_e3_re;
                w_sm_x = r_comp ? r_e2_im : r_e2_re;
            end
        endcase
    end

    cmaf_smooth u_smooth (
        .i_clk    (i_clk),
        .i_load   (w_mul_load),
        .i_e      (w_sm_e),
        .i_x      (w_sm_x),
        .i_gain   (w_gain),
        .o_e_next (w_sm_next)
    );

    assign w_ring_we    = w_sma_fill || w_sma_repl;
    assign w_ring_waddr = w_sma_fill ? r_fill[AW-1:0] : r_head;

    cmaf_ring #(
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_entry),
        .i_re    (w_ring_rd),
        .i_raddr (r_head),
        .o_rdata (w_old)
    );

    // Divide by magnitude with half the count added, so ties round away from zero.
    assign w_sum_sel  = r_comp ? r_sum_im : r_sum_re;
    assign w_mag      = w_sum_sel[UW-1] ? UW'(0) - w_sum_sel : w_sum_sel;
    assign w_dividend = QW'(w_mag) + QW'(r_cnt >> 1);

    cmaf_div #(
        .DIVISOR_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_cnt),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_exp_re = exp_result(r_mode, r_e1_re, r_e2_re, r_e3_re);
    assign w_exp_im = exp_result(r_mode, r_e1_im, r_e2_im, r_e3_im);

    // Control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmaf_pkg::ST_IDLE;
            r_mode      <= cmaf_pkg::MODE_SMA;
            r_window    <= 8'd1;
            r_gain      <= cmaf_pkg::GAIN_ONE;
            r_sum_re    <= '0;
            r_sum_im    <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_e1_re     <= '0;
            r_e1_im     <= '0;
            r_e2_re     <= '0;
            r_e2_im     <= '0;
            r_e3_re     <= '0;
            r_e3_im     <= '0;
            r_stg       <= '0;
            r_comp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr) begin
                case (paddr[3:2])
                    cmaf_pkg::REG_MODE:   r_mode   <= pwdata[2:0];
                    cmaf_pkg::REG_WINDOW: r_window <= pwdata[7:0];
                    cmaf_pkg::REG_GAIN:   r_gain   <= pwdata[cmaf_pkg::GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_in_accept) begin
                r_stg  <= '0;
                r_comp <= 1'b0;
                if (i_first_of_channel) begin
                    if (w_exp_mode) begin
                        r_e1_re <= {i_sample_re, 8'h00};
                        r_e2_re <= {i_sample_re, 8'h00};
                        r_e3_re <= {i_sample_re, 8'h00};
                        r_e1_im <= {i_sample_im, 8'h00};
                        r_e2_im <= {i_sample_im, 8'h00};
                        r_e3_im <= {i_sample_im, 8'h00};
                    end else begin
                        r_sum_re <= '0;
                        r_sum_im <= '0;
                        r_head   <= '0;
                        r_fill   <= '0;
                    end
                end
            end

            if (w_stage_wr) begin
                case (r_stg)
                    2'd0: begin
                        if (r_comp) r_e1_im <= w_sm_next;
                        else        r_e1_re <= w_sm_next;
                    end
                    2'd1: begin
                        if (r_comp) r_e2_im <= w_sm_next;
                        else        r_e2_re <= w_sm_next;
                    end
                    default: begin
                        if (r_comp) r_e3_im <= w_sm_next;
                        else        r_e3_re <= w_sm_next;
                    end
                endcase
                if (r_comp) begin
                    r_stg <= r_stg + 2'd1;
                end
                r_comp <= !r_comp;
            end

            if (w_sma_fill) begin
                r_sum_re <= r_sum_re + UW'(signed'(r_x_re));
                r_sum_im <= r_sum_im + UW'(signed'(r_x_im));
                r_fill   <= r_fill + CW'(1);
            end

            if (w_sma_repl) begin
                r_sum_re <= r_sum_re + UW'(signed'(r_x_re)) - UW'(signed'(w_old[15:0]));
                r_sum_im <= r_sum_im + UW'(signed'(r_x_im)) - UW'(signed'(w_old[31:16]));
                r_head   <= (w_head_inc >= w_n) ? '0 : w_head_inc[AW-1:0];
            end

            if (w_div_take) begin
                r_comp <= 1'b1;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x_re <= i_sample_re;
            r_x_im <= i_sample_im;
        end
        if (w_sma_fill) begin
            r_cnt <= r_fill + CW'(1);
        end else if (w_ring_rd) begin
            r_cnt <= w_n;
        end
        if (w_sma_fill || w_ring_rd) begin
            r_res_sat <= 1'b0;
        end
        if (w_exp_take) begin
            r_res_re  <= w_exp_re[15:0];
            r_res_im  <= w_exp_im[15:0];
            r_res_sat <= w_exp_re[16] || w_exp_im[16];
        end
        if (w_div_take) begin
            if (r_comp) r_res_im <= sma_result(w_sum_sel[UW-1], w_quot);
            else        r_res_re <= sma_result(w_sum_sel[UW-1], w_quot);
        end
        if (w_out_load) begin
            r_out_re  <= r_res_re;
            r_out_im  <= r_res_im;
            r_out_sat <= r_res_sat;
        end
    end

    always_comb begin
        case (paddr[3:2])
            cmaf_pkg::REG_MODE:   prdata = DW'(r_mode);
            cmaf_pkg::REG_WINDOW: prdata = DW'(r_window);
            cmaf_pkg::REG_GAIN:   prdata = DW'(r_gain);
            default:              prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = w_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_avg_re    = r_out_re;
    assign o_avg_im    = r_out_im;
    assign o_saturated = r_out_sat;

    // Only one sample word is in flight at a time.
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a sample word is in flight");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmaf_pkg::ST_DIV_GO) |-> !w_div_busy)
        else $error("divider started while busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_MAX))
        else $error("fill count past ring depth");

    a_done_hands_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmaf_pkg::ST_DONE && (!r_out_valid || !i_out_stall))
        |=> (o_out_valid && !o_in_stall))
        else $error("finished word not moved to the output register");

    a_sat_cascade_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmaf_pkg::ST_EXP_OUT && r_mode != cmaf_pkg::MODE_DEMA &&
         r_mode != cmaf_pkg::MODE_TEMA) |=> !r_res_sat)
        else $error("saturation flag raised outside the cascade modes");

endmodule
